FILE: src/u8d_pkg.sv
// shared types and constants for the utf-8 stream decoder
package u8d_pkg;

    localparam int DATA_BITS   = 8;
    localparam int CODE_BITS   = 16;
    localparam int START_BITS  = 32;
    localparam int STATUS_BITS = 2;
    localparam int PART_BITS   = 10;

    localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_MALFORMED = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_TRUNCATED = 2'd2;

    localparam logic [CODE_BITS-1:0] CODE_MIN_TWO   = 16'h0080;
    localparam logic [CODE_BITS-1:0] CODE_MIN_THREE = 16'h0800;

    // continuation bytes still expected
    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_ONE  = 2'd1;
    localparam logic [1:0] PEND_TWO  = 2'd2;

    typedef struct packed {
        logic [DATA_BITS-1:0] data_byte;
        logic                 final_byte;
    } in_item_t;

    typedef struct packed {
        logic                   valid;
        logic [CODE_BITS-1:0]   code_value;
        logic [START_BITS-1:0]  start_offset;
        logic [STATUS_BITS-1:0] status;
    } result_t;

endpackage

FILE: src/u8d_in_stage.sv
// input register holding one accepted byte until the decoder consumes it
module u8d_in_stage
    import u8d_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  in_item_t s_item,
    input  logic     advance,
    output logic     item_valid,
    output in_item_t item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign s_tready   = !valid_reg || advance;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: src/u8d_core.sv
// sequence state and combinational decode of one byte
module u8d_core
    import u8d_pkg::*;
#(
    parameter int OFFSET_BITS = 32
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     consume,
    input  in_item_t item,
    output result_t  result
);

    logic [1:0]             pending_reg, pending_next;
    logic                   three_reg, three_next;
    logic [PART_BITS-1:0]   partial_reg, partial_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] seq_start_reg, seq_start_next;

    logic [5:0]             cont;
    logic [CODE_BITS-1:0]   full_value;
    logic                   good;
    logic [OFFSET_BITS+START_BITS-1:0] start_ext;

    assign cont       = item.data_byte[5:0];
    assign full_value = {partial_reg, cont};
    assign good       = three_reg ? (full_value >= CODE_MIN_THREE)
                                  : (full_value >= CODE_MIN_TWO);

    always_comb begin
        pending_next   = pending_reg;
        three_next     = three_reg;
        partial_next   = partial_reg;
        seq_start_next = seq_start_reg;
        pos_next       = pos_reg + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
        result.valid        = 1'b0;
        result.code_value   = '0;
        result.status       = STATUS_OK;

        if (pending_reg == PEND_NONE) begin
            seq_start_next = pos_reg;
            case (item.data_byte) inside
                [8'h00:8'h7F]: begin
                    result.valid      = 1'b1;
                    result.code_value = {8'h00, item.data_byte};
                end
                [8'hC0:8'hDF]: begin
                    partial_next = {5'b0, item.data_byte[4:0]};
                    pending_next = PEND_ONE;
                    three_next   = 1'b0;
                end
                [8'hE0:8'hEF]: begin
                    partial_next = {6'b0, item.data_byte[3:0]};
                    pending_next = PEND_TWO;
                    three_next   = 1'b1;
                end
                default: begin
                    result.valid  = 1'b1;
                    result.status = STATUS_MALFORMED;
                end
            endcase
        end else if (pending_reg[1]) begin
            partial_next = {partial_reg[3:0], cont};
            pending_next = PEND_ONE;
        end else begin
            result.valid = 1'b1;
            if (good) begin
                result.code_value = full_value;
            end else begin
                result.status = STATUS_MALFORMED;
            end
            pending_next = PEND_NONE;
            three_next   = 1'b0;
            partial_next = '0;
        end

        // low 32 bits of the offset, zero-extended when the counter is narrower
        start_ext           = {{START_BITS{1'b0}}, seq_start_next};
        result.start_offset = start_ext[START_BITS-1:0];

        if (item.final_byte) begin
            if (pending_next != PEND_NONE && !result.valid) begin
                result.valid  = 1'b1;
                result.status = STATUS_TRUNCATED;
            end
            pending_next   = PEND_NONE;
            three_next     = 1'b0;
            partial_next   = '0;
            pos_next       = '0;
            seq_start_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg   <= PEND_NONE;
            three_reg     <= 1'b0;
            partial_reg   <= '0;
            pos_reg       <= '0;
            seq_start_reg <= '0;
        end else if (consume) begin
            pending_reg   <= pending_next;
            three_reg     <= three_next;
            partial_reg   <= partial_next;
            pos_reg       <= pos_next;
            seq_start_reg <= seq_start_next;
        end
    end

endmodule

FILE: src/u8d_out_stage.sv
// result register that holds a decoded item until the receiver takes it
module u8d_out_stage
    import u8d_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    m_tready,
    input  logic    item_valid,
    input  result_t result,
    output logic    advance,
    output logic    m_tvalid,
    output result_t held
);

    logic    valid_reg;
    logic    valid_next;
    result_t held_reg;
    logic    load;

    assign advance = item_valid && (!valid_reg || m_tready);
    assign load    = advance && result.valid;

    always_comb begin
        valid_next = valid_reg && !m_tready;
        if (advance) begin
            valid_next = result.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            held_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign held     = held_reg;

endmodule

FILE: src/utf8_stream_decoder.sv
// utf-8 byte stream to 16-bit code point decoder, top level
//
// input: one buffer byte per transfer on s_tdata, s_tlast on the buffer's
// last byte. output: one transfer per completed code point, malformed
// sequence or sequence cut off by the last byte; m_tdata carries the code
// point and the offset of the sequence's first byte, m_tuser the status
// (ok, malformed, truncated). a byte that only opens or extends a sequence
// gives no output transfer.
// a byte is held in the input register, decoded combinationally from there
// and its result loaded into the result register that drives m_tvalid.
// throughput: one byte per clock while the result register is empty or
// m_tready is high, set by the single decode pass between the two registers.
// when the receiver holds m_tready low, the result register keeps its
// transfer and the input register fills; s_tready falls only while both
// are full. reset clears the sequence state and the offset counter; the
// offset also restarts at zero after each s_tlast byte.
module utf8_stream_decoder
    import u8d_pkg::*;
#(
    parameter int OFFSET_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tlast,   // final_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // code_value[15:0], start_offset[47:16]
    output logic [1:0]  m_tuser    // status
);

    in_item_t s_item;
    in_item_t item;
    logic     item_valid;
    logic     advance;
    result_t  result;
    result_t  held;

    assign s_item.data_byte  = s_tdata;
    assign s_item.final_byte = s_tlast;

    u8d_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    u8d_core #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .consume (advance),
        .item    (item),
        .result  (result)
    );

    u8d_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .m_tready   (m_tready),
        .item_valid (item_valid),
        .result     (result),
        .advance    (advance),
        .m_tvalid   (m_tvalid),
        .held       (held)
    );

    assign m_tdata = {held.start_offset, held.code_value};
    assign m_tuser = held.status;

    // a non-ok result never carries a code point
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != STATUS_OK) |-> m_tdata[15:0] == '0)
        else $error("error result with nonzero code point");

    // status is one of the three defined codes
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == STATUS_OK) || (m_tuser == STATUS_MALFORMED) ||
                     (m_tuser == STATUS_TRUNCATED))
        else $error("undefined status code");

    // input backpressure only comes from a stalled full result register
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output stall");

    // a truncated sequence reports no code point
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STATUS_TRUNCATED) |-> m_tdata[15:0] == '0)
        else $error("truncated result with nonzero code point");

endmodule
